[rtl/ffca_pkg.sv]
package ffca_pkg;

  localparam int NUM_NODES   = 8;
  localparam int NUM_ENTRIES = 64;
  localparam int ID_BITS     = 32;

  localparam int NODE_W   = 3;
  localparam int CPU_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;
  localparam int NCNT_W   = 4;
  localparam int SLOT_W   = $clog2(NUM_ENTRIES);
  localparam int SCNT_W   = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_DEPLOYED  = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_NODE_CAP   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NODE_SCAN,
    S_SLOT_SCAN,
    S_REL_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [CPU_W-1:0]   cpu;
    logic [NODE_W-1:0]  node;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic              clr_en;
    logic [SLOT_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

[rtl/ffca_entry_store.sv]
module ffca_entry_store (
  input  logic              clk,
  input  logic              rst_n,
  input  ffca_pkg::mem_ctl_t ctl,
  input  ffca_pkg::entry_t   wr_data,
  output ffca_pkg::entry_t   rd_data,
  output logic              rd_valid
);
  import ffca_pkg::*;

  entry_t                 mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  entry_t                 rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid_r[ctl.wr_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[ctl.rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

[rtl/first_fit_cpu_allocator_top.sv]
// First-fit CPU allocator. One request at a time: in_ready is high only while the block is
// idle, and a finished result may wait in the output register while the next request is
// taken. A deploy checks one node per cycle, then walks the entry table one slot per cycle
// through the single read port of the entry memory until a free slot shows up, then commits
// once the output register is free. A release always walks all 64 entries to find the
// lowest node and newest entry with the id, then commits. The entry memory needs no
// clearing after reset; per-slot valid flops are cleared at once.
module first_fit_cpu_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_vnf_id,
  input  logic [15:0] in_cpu_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_node_index,
  output logic [15:0] out_cpu_granted
);
  import ffca_pkg::*;

  state_t state_r, state_nxt;

  logic [NCNT_W-1:0]  node_count_r;
  logic [CPU_W-1:0]   node_cap_r;
  logic [CPU_W-1:0]   used_r [NUM_NODES];
  logic [STAMP_W-1:0] deploy_cnt_r;

  logic [ID_BITS-1:0] req_id_r;
  logic [CPU_W-1:0]   req_cpu_r;

  logic [NCNT_W-1:0]  node_cnt_r;
  logic [SCNT_W-1:0]  scan_addr_r;
  logic               pipe_vld_r;
  logic [SLOT_W-1:0]  pipe_slot_r;

  logic               best_found_r;
  logic [SLOT_W-1:0]  best_slot_r;
  logic [NODE_W-1:0]  best_node_r;
  logic [STAMP_W-1:0] best_age_r;
  logic [CPU_W-1:0]   best_cpu_r;

  status_t            res_status_r;
  logic [NODE_W-1:0]  res_node_r;
  logic [CPU_W-1:0]   res_cpu_r;
  logic [SLOT_W-1:0]  slot_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [NODE_W-1:0]  out_node_r;
  logic [CPU_W-1:0]   out_cpu_r;

  mem_ctl_t           mem_ctl;
  entry_t             wr_data;
  entry_t             rd_data;
  logic               rd_valid;

  logic [NCNT_W-1:0]  active_nodes;
  logic [CPU_W-1:0]   cur_used;
  logic [CPU_W-1:0]   avail;
  logic               node_fit;
  logic               node_end;
  logic               issue;
  logic               scan_last;
  logic [STAMP_W-1:0] age;
  logic               cand;
  logic               take;
  logic               free_hit;
  logic               in_fire;
  logic               commit_go;
  logic               rel_found;

  ffca_entry_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // Node search: one node per cycle against the shared compare.
  assign active_nodes = (node_count_r > NCNT_W'(NUM_NODES)) ? NCNT_W'(NUM_NODES) : node_count_r;
  assign cur_used     = used_r[node_cnt_r[NODE_W-1:0]];
  assign avail        = (node_cap_r > cur_used) ? (node_cap_r - cur_used) : '0;
  assign node_fit     = (avail >= req_cpu_r);
  assign node_end     = (node_cnt_r >= active_nodes);

  // Entry walk: read issued one cycle, data checked the next.
  assign issue     = (scan_addr_r < SCNT_W'(NUM_ENTRIES));
  assign scan_last = pipe_vld_r && (pipe_slot_r == SLOT_W'(NUM_ENTRIES - 1));
  assign free_hit  = pipe_vld_r && !rd_valid;
  assign age       = deploy_cnt_r - rd_data.stamp;
  assign cand      = pipe_vld_r && rd_valid && (rd_data.id == req_id_r);
  assign take      = cand && (!best_found_r || (rd_data.node < best_node_r) ||
                              ((rd_data.node == best_node_r) && (age < best_age_r)));
  assign rel_found = best_found_r || take;

  assign in_fire   = in_valid && in_ready;
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_req_type ? S_REL_SCAN : S_NODE_SCAN;
        end
      end
      S_NODE_SCAN: begin
        if (node_end) begin
          state_nxt = S_COMMIT;
        end else if (node_fit) begin
          state_nxt = S_SLOT_SCAN;
        end
      end
      S_SLOT_SCAN: begin
        if (free_hit || scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_REL_SCAN: begin
        if (scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    mem_ctl.rd_en   = 1'b0;
    mem_ctl.rd_addr = scan_addr_r[SLOT_W-1:0];
    mem_ctl.wr_en   = 1'b0;
    mem_ctl.clr_en  = 1'b0;
    mem_ctl.wr_addr = slot_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_SLOT_SCAN, S_REL_SCAN: begin
        mem_ctl.rd_en = issue;
      end
      S_COMMIT: begin
        mem_ctl.wr_en  = commit_go && (res_status_r == ST_DEPLOYED);
        mem_ctl.clr_en = commit_go && (res_status_r == ST_RELEASED);
      end
      default: begin
      end
    endcase
  end

  assign wr_data.id    = req_id_r;
  assign wr_data.cpu   = req_cpu_r;
  assign wr_data.node  = res_node_r;
  assign wr_data.stamp = deploy_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NCNT_W'(NUM_NODES);
      node_cap_r   <= '0;
      for (int i = 0; i < NUM_NODES; i++) begin
        used_r[i] <= '0;
      end
      deploy_cnt_r <= '0;
      scan_addr_r  <= '0;
      pipe_vld_r   <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NODE_COUNT: node_count_r <= cfg_wdata[NCNT_W-1:0];
          CFG_NODE_CAP:   node_cap_r   <= cfg_wdata[CPU_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        req_id_r     <= in_vnf_id[ID_BITS-1:0];
        req_cpu_r    <= in_cpu_amount;
        node_cnt_r   <= '0;
        best_found_r <= 1'b0;
      end

      if ((state_r == S_SLOT_SCAN) || (state_r == S_REL_SCAN)) begin
        if (issue) begin
          scan_addr_r <= scan_addr_r + SCNT_W'(1);
        end
        pipe_vld_r  <= issue;
        pipe_slot_r <= scan_addr_r[SLOT_W-1:0];
      end else begin
        scan_addr_r <= '0;
        pipe_vld_r  <= 1'b0;
      end

      if (state_r == S_NODE_SCAN) begin
        if (node_end) begin
          res_status_r <= ST_NO_FIT;
          res_node_r   <= '0;
          res_cpu_r    <= '0;
        end else if (node_fit) begin
          res_node_r <= node_cnt_r[NODE_W-1:0];
        end else begin
          node_cnt_r <= node_cnt_r + NCNT_W'(1);
        end
      end

      if (state_r == S_SLOT_SCAN) begin
        if (free_hit) begin
          slot_r       <= pipe_slot_r;
          res_status_r <= ST_DEPLOYED;
          res_cpu_r    <= req_cpu_r;
        end else if (scan_last) begin
          res_status_r <= ST_FULL;
          res_node_r   <= '0;
          res_cpu_r    <= '0;
        end
      end

      if (state_r == S_REL_SCAN) begin
        if (take) begin
          best_found_r <= 1'b1;
          best_slot_r  <= pipe_slot_r;
          best_node_r  <= rd_data.node;
          best_age_r   <= age;
          best_cpu_r   <= rd_data.cpu;
        end
        if (scan_last) begin
          // the last slot can still win, so merge it here
          res_status_r <= rel_found ? ST_RELEASED : ST_NOT_FOUND;
          slot_r       <= take ? pipe_slot_r : best_slot_r;
          res_node_r   <= !rel_found ? '0 : (take ? rd_data.node : best_node_r);
          res_cpu_r    <= !rel_found ? '0 : (take ? rd_data.cpu : best_cpu_r);
        end
      end

      if (commit_go) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_node_r   <= res_node_r;
        out_cpu_r    <= res_cpu_r;
        if (res_status_r == ST_DEPLOYED) begin
          used_r[res_node_r] <= used_r[res_node_r] + res_cpu_r;
          deploy_cnt_r       <= deploy_cnt_r + STAMP_W'(1);
        end
        if (res_status_r == ST_RELEASED) begin
          used_r[res_node_r] <= (used_r[res_node_r] > res_cpu_r) ?
                                (used_r[res_node_r] - res_cpu_r) : '0;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_node_index  = out_node_r;
  assign out_cpu_granted = out_cpu_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_valid)
    else $error("committed result not presented");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_FIT || out_status == ST_FULL ||
                  out_status == ST_NOT_FOUND)
    |-> (out_node_index == '0) && (out_cpu_granted == '0))
    else $error("failed transaction carries node or cpu");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go && (res_status_r == ST_DEPLOYED)
    |=> deploy_cnt_r == STAMP_W'($past(deploy_cnt_r) + STAMP_W'(1)))
    else $error("deploy counter did not advance");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ffca_pkg::*;

  localparam logic REQ_DEPLOY  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam int   ID_POOL_SZ  = 20;

  typedef struct {
    status_t              status;
    logic [NODE_W-1:0]    node;
    logic [CPU_W-1:0]     cpu;
  } alloc_result_t;

  typedef struct packed {
    logic                 kind;
    logic [31:0]          id;
    logic [CPU_W-1:0]     cpu;
  } alloc_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_NODE_COUNT;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_DEPLOY;
  logic [31:0] in_vnf_id = '0;
  logic [15:0] in_cpu_amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_node_index;
  logic [15:0] out_cpu_granted;

  first_fit_cpu_allocator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_vnf_id       (in_vnf_id),
    .in_cpu_amount   (in_cpu_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_node_index  (out_node_index),
    .out_cpu_granted (out_cpu_granted)
  );

  always #2 clk = ~clk;

  // shadow of the allocator state
  logic [NCNT_W-1:0]  nodes_active;
  logic [CPU_W-1:0]   node_cap;
  logic [CPU_W-1:0]   node_used  [NUM_NODES];
  bit                 slot_valid [NUM_ENTRIES];
  logic [31:0]        slot_id    [NUM_ENTRIES];
  logic [CPU_W-1:0]   slot_cpu   [NUM_ENTRIES];
  logic [NODE_W-1:0]  slot_node  [NUM_ENTRIES];
  logic [STAMP_W-1:0] slot_stamp [NUM_ENTRIES];
  logic [STAMP_W-1:0] deploy_count;

  alloc_req_t    pending_reqs[$];
  alloc_result_t expected_grants[$];
  logic [31:0]   id_pool[ID_POOL_SZ];
  logic [31:0]   stray_ids[$];

  bit in_fire = 1'b0;
  bit idle_on = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int errors = 0;
  int n_placed = 0, n_no_fit = 0, n_full = 0, n_freed = 0, n_unknown = 0;

  function automatic alloc_result_t allocate(input logic kind, input logic [31:0] id,
                                             input logic [CPU_W-1:0] demand);
    alloc_result_t      res;
    int                 active;
    int                 avail;
    int                 node;
    bit                 fit;
    int                 slot;
    bit                 got;
    int                 best;
    bit                 found;
    logic [NODE_W-1:0]  best_node;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] best_age;
    res = '{status: ST_NO_FIT, node: '0, cpu: '0};
    if (kind == REQ_DEPLOY) begin
      active = (nodes_active > NUM_NODES) ? NUM_NODES : int'(nodes_active);
      fit = 1'b0;
      node = 0;
      for (int i = 0; i < active && !fit; i++) begin
        avail = (node_cap > node_used[i]) ? int'(node_cap) - int'(node_used[i]) : 0;
        if (avail >= int'(demand)) begin
          node = i;
          fit = 1'b1;
        end
      end
      if (!fit) return res;
      got = 1'b0;
      slot = 0;
      for (int s = 0; s < NUM_ENTRIES && !got; s++) begin
        if (!slot_valid[s]) begin
          slot = s;
          got = 1'b1;
        end
      end
      if (!got) begin
        res.status = ST_FULL;
        return res;
      end
      slot_valid[slot] = 1'b1;
      slot_id[slot]    = id;
      slot_cpu[slot]   = demand;
      slot_node[slot]  = node[NODE_W-1:0];
      slot_stamp[slot] = deploy_count;
      deploy_count     = deploy_count + 1;
      node_used[node]  = node_used[node] + demand;
      res = '{status: ST_DEPLOYED, node: node[NODE_W-1:0], cpu: demand};
    end else begin
      found = 1'b0;
      best = 0;
      best_node = '0;
      best_age = '0;
      // lowest node wins, then the youngest entry, then the lowest slot
      for (int s = 0; s < NUM_ENTRIES; s++) begin
        if (slot_valid[s] && slot_id[s] == id) begin
          age = deploy_count - slot_stamp[s];
          if (!found || slot_node[s] < best_node ||
              (slot_node[s] == best_node && age < best_age)) begin
            best = s;
            best_node = slot_node[s];
            best_age = age;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        res.status = ST_NOT_FOUND;
        return res;
      end
      slot_valid[best] = 1'b0;
      node_used[best_node] = (node_used[best_node] > slot_cpu[best]) ?
                             node_used[best_node] - slot_cpu[best] : '0;
      res = '{status: ST_RELEASED, node: best_node, cpu: slot_cpu[best]};
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // request driver
  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      // hold until the transaction is taken
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      in_valid      <= 1'b1;
      in_req_type   <= pending_reqs[0].kind;
      in_vnf_id     <= pending_reqs[0].id;
      in_cpu_amount <= pending_reqs[0].cpu;
      void'(pending_reqs.pop_front());
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_grants.push_back(allocate(in_req_type, in_vnf_id, in_cpu_amount));
  end

  always @(posedge clk) begin : grant_check
    alloc_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: status %0d node %0d cpu %0d", $time,
                 out_status, out_node_index, out_cpu_granted);
      end else begin
        want = expected_grants.pop_front();
        case (want.status)
          ST_DEPLOYED:  n_placed++;
          ST_NO_FIT:    n_no_fit++;
          ST_FULL:      n_full++;
          ST_RELEASED:  n_freed++;
          default:      n_unknown++;
        endcase
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_node_index !== want.node) begin
          errors++;
          $display("%0t: node_index expected %0d actual %0d", $time, want.node,
                   out_node_index);
        end
        if (out_cpu_granted !== want.cpu) begin
          errors++;
          $display("%0t: cpu_granted expected %0d actual %0d", $time, want.cpu,
                   out_cpu_granted);
        end
      end
    end
  end

  task automatic add_req(input logic kind, input logic [31:0] id, input logic [15:0] cpu);
    pending_reqs.push_back('{kind: kind, id: id, cpu: cpu});
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) nodes_active = val[NCNT_W-1:0];
    else node_cap = val;
  endtask

  task automatic configure(input logic [3:0] cnt, input logic [15:0] cap);
    wait_quiet();
    write_reg(CFG_NODE_COUNT, {12'd0, cnt});
    write_reg(CFG_NODE_CAP, cap);
  endtask

  task automatic run_phase(input logic [3:0] cnt, input int cap, input int n,
                           input int deploy_pct, input bit idle);
    int          r;
    logic [31:0] id;
    logic [15:0] amt;
    configure(cnt, cap[15:0]);
    idle_on = idle;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < deploy_pct) begin
        if (r < 90) begin
          id = id_pool[$urandom_range(0, ID_POOL_SZ - 1)];
        end else begin
          id = $urandom;
          stray_ids.push_back(id);
        end
        r = $urandom_range(0, 99);
        if (r < 5) amt = '0;
        else if (r < 10) amt = 16'($urandom);
        else if (r < 15) amt = cap[15:0];
        else amt = 16'($urandom_range(1, cap / 8 + 1));
        add_req(REQ_DEPLOY, id, amt);
      end else begin
        if (r < 70) id = id_pool[$urandom_range(0, ID_POOL_SZ - 1)];
        else if (r < 90 && stray_ids.size() > 0)
          id = stray_ids[$urandom_range(0, stray_ids.size() - 1)];
        else id = $urandom;
        add_req(REQ_RELEASE, id, 16'($urandom));
      end
    end
  endtask

  initial begin
    nodes_active = 4'd8;
    node_cap = '0;
    deploy_count = '0;
    for (int i = 0; i < NUM_NODES; i++) node_used[i] = '0;
    for (int s = 0; s < NUM_ENTRIES; s++) begin
      slot_valid[s] = 1'b0;
      slot_id[s]    = '0;
      slot_cpu[s]   = '0;
      slot_node[s]  = '0;
      slot_stamp[s] = '0;
    end
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < ID_POOL_SZ; i++) id_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: eight nodes with no capacity
    add_req(REQ_DEPLOY, 32'h1, 16'd0);              // zero demand fits a full node
    add_req(REQ_DEPLOY, 32'h2, 16'd1);
    add_req(REQ_RELEASE, 32'h1, 16'd0);
    add_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);

    configure(4'd8, 16'hFFFF);
    add_req(REQ_DEPLOY, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(REQ_DEPLOY, 32'h5, 16'd1);
    add_req(REQ_DEPLOY, 32'h6, 16'hFFFF);
    add_req(REQ_DEPLOY, 32'hA5A5_5A5A, 16'd100);    // same id twice on one node
    add_req(REQ_DEPLOY, 32'hA5A5_5A5A, 16'd200);
    add_req(REQ_RELEASE, 32'hA5A5_5A5A, 16'd0);     // newest one goes
    add_req(REQ_DEPLOY, 32'h0, 16'd0);
    add_req(REQ_RELEASE, 32'h0, 16'hFFFF);

    configure(4'd8, 16'd50);                        // capacity now below usage
    add_req(REQ_DEPLOY, 32'h7, 16'd10);
    add_req(REQ_DEPLOY, 32'h8, 16'd51);

    configure(4'd0, 16'd50);                        // no nodes at all
    add_req(REQ_DEPLOY, 32'h9, 16'd0);

    configure(4'd15, 16'hFFFF);                     // clipped to eight nodes
    add_req(REQ_DEPLOY, 32'hA, 16'hFFFF);

    configure(4'd1, 16'hFFFF);                      // release from inactive nodes and from node 0
    add_req(REQ_RELEASE, 32'h6, 16'd0);
    add_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'd0);
    add_req(REQ_RELEASE, 32'hA5A5_5A5A, 16'd0);

    run_phase(4'd8, 65535, 90, 85, 1'b1);           // fills the entry table
    run_phase(4'd8, 0, 20, 60, 1'b1);
    run_phase(4'd3, 2000, 100, 35, 1'b0);
    run_phase(4'd15, 20000, 80, 55, 1'b1);
    run_phase(4'd1, 500, 60, 50, 1'b1);
    run_phase(4'd0, 1000, 20, 50, 1'b0);
    run_phase(4'd5, 65535, 70, 50, 1'b1);
    run_phase(4'd8, 40000, 60, 40, 1'b1);

    wait_quiet();
    repeat (100) @(posedge clk);
    if (expected_grants.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_grants.size());
    end
    $display("requests checked: %0d placed, %0d no-fit, %0d table-full, %0d freed, %0d unknown id",
             n_placed, n_no_fit, n_full, n_freed, n_unknown);
    $display("node counts 0..15 and capacities 0..65535 exercised, %0d field errors", errors);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
rtl/ffca_pkg.sv
rtl/ffca_entry_store.sv
rtl/first_fit_cpu_allocator_top.sv
tb/tb.sv
